// ----- sv/sifq_pkg.sv -----
// shared constants, status codes and microcode rom for the simpson integrator
package sifq_pkg;

  localparam int FRAC_BITS      = 12;
  localparam int MAX_PARTITIONS = 4096;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_SATURATED = 2'd2;

  localparam logic [63:0] INT_MIN = {1'b1, {63{1'b0}}};
  localparam logic [63:0] INT_MAX = {1'b0, {63{1'b1}}};

  // datapath operations
  localparam logic [3:0] OP_WAIT    = 4'd0;
  localparam logic [3:0] OP_CHECK   = 4'd1;
  localparam logic [3:0] OP_DIV     = 4'd2;
  localparam logic [3:0] OP_HSET    = 4'd3;
  localparam logic [3:0] OP_POINT   = 4'd4;
  localparam logic [3:0] OP_NOP     = 4'd5;
  localparam logic [3:0] OP_MAGS    = 4'd6;
  localparam logic [3:0] OP_MULLO   = 4'd7;
  localparam logic [3:0] OP_MULHI   = 4'd8;
  localparam logic [3:0] OP_ACC     = 4'd9;
  localparam logic [3:0] OP_OCHK    = 4'd10;
  localparam logic [3:0] OP_OUT_Q   = 4'd11;
  localparam logic [3:0] OP_OUT_BAD = 4'd12;
  localparam logic [3:0] OP_OUT_SAT = 4'd13;
  localparam logic [3:0] OP_DIV3    = 4'd14;

  // jump conditions
  localparam logic [3:0] CND_NEVER    = 4'd0;
  localparam logic [3:0] CND_ITEM     = 4'd1;
  localparam logic [3:0] CND_BAD_N    = 4'd2;
  localparam logic [3:0] CND_DIV_MORE = 4'd3;
  localparam logic [3:0] CND_PT_MORE  = 4'd4;
  localparam logic [3:0] CND_OVF      = 4'd5;
  localparam logic [3:0] CND_PROD_OVF = 4'd6;
  localparam logic [3:0] CND_OUT_FREE = 4'd7;
  localparam logic [3:0] CND_D3_MORE  = 4'd8;

  // program addresses
  localparam logic [3:0] PC_WAIT  = 4'd0;
  localparam logic [3:0] PC_CHECK = 4'd1;
  localparam logic [3:0] PC_DIV   = 4'd2;
  localparam logic [3:0] PC_POINT = 4'd4;
  localparam logic [3:0] PC_DIV3  = 4'd12;
  localparam logic [3:0] PC_BAD   = 4'd14;
  localparam logic [3:0] PC_SAT   = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] cond;
    logic [3:0] target;
    logic       hold;
  } uword_t;

  // cond true: go to target; false: hold or fall through
  localparam uword_t UCODE [16] = '{
    '{OP_WAIT,    CND_ITEM,     PC_CHECK, 1'b1},
    '{OP_CHECK,   CND_BAD_N,    PC_BAD,   1'b0},
    '{OP_DIV,     CND_DIV_MORE, PC_DIV,   1'b0},
    '{OP_HSET,    CND_NEVER,    PC_WAIT,  1'b0},
    '{OP_POINT,   CND_PT_MORE,  PC_POINT, 1'b0},
    '{OP_NOP,     CND_NEVER,    PC_WAIT,  1'b0},
    '{OP_NOP,     CND_NEVER,    PC_WAIT,  1'b0},
    '{OP_MAGS,    CND_OVF,      PC_SAT,   1'b0},
    '{OP_MULLO,   CND_NEVER,    PC_WAIT,  1'b0},
    '{OP_MULHI,   CND_NEVER,    PC_WAIT,  1'b0},
    '{OP_ACC,     CND_NEVER,    PC_WAIT,  1'b0},
    '{OP_OCHK,    CND_PROD_OVF, PC_SAT,   1'b0},
    '{OP_DIV3,    CND_D3_MORE,  PC_DIV3,  1'b0},
    '{OP_OUT_Q,   CND_OUT_FREE, PC_WAIT,  1'b1},
    '{OP_OUT_BAD, CND_OUT_FREE, PC_WAIT,  1'b1},
    '{OP_OUT_SAT, CND_OUT_FREE, PC_WAIT,  1'b1}
  };

endpackage

// ----- sv/simpson_integral_fixed_quadratic.sv -----
// simpson integrator of x*x+2x-5 run by a microcoded sequencer
// each word runs through a 64-step serial divide for the step, the point loop
//   (one point per cycle) and a 4-step divide by three; a new word is accepted
//   only once the sequencer is back at its wait step
// a zero, odd or oversized count goes from the check step straight to the bad-count output step
// synchronous reset returns the sequencer to its wait step and drops result_valid
module simpson_integral_fixed_quadratic (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [23:0] lower_limit,
  input  logic signed [23:0] upper_limit,
  input  logic        [12:0] partitions,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [63:0] integral,
  output logic        [1:0]  status
);
  import sifq_pkg::*;

  localparam logic signed [51:0] POLY_C = 52'sd5 <<< (2 * FRAC_BITS);
  localparam logic [17:0] D3_RECIP = 18'd174763;

  logic [3:0]         pc;
  logic [3:0]         pc_next;
  uword_t             uw;
  logic               cond;

  logic signed [23:0] lower;
  logic signed [23:0] upper;
  logic [12:0]        count;
  logic               bad_n;

  logic [5:0]         cnt;
  logic [63:0]        dq;
  logic [12:0]        rem;
  logic [12:0]        dvs;
  logic [13:0]        div_r;
  logic [13:0]        div_sub;
  logic               div_ge;
  logic               h_neg;
  logic signed [24:0] diff;
  logic signed [24:0] diff_abs;

  logic [17:0]        d3_v;
  logic [35:0]        d3_p;
  logic [15:0]        d3_q;
  logic [17:0]        d3_back;
  logic [17:0]        d3_left;

  logic signed [24:0] h;
  logic signed [24:0] h_abs;
  logic signed [23:0] x;
  logic signed [24:0] x_sum;
  logic [12:0]        idx;
  logic [1:0]         wsel;

  logic signed [47:0] s1_sq;
  logic signed [23:0] s1_x;
  logic [1:0]         s1_w;
  logic               s1_v;
  logic signed [51:0] f_val;
  logic signed [51:0] s2_fw;
  logic               s2_v;

  logic signed [63:0] sum;
  logic signed [63:0] add_b;
  logic signed [64:0] add_t;
  logic               add_ovf;
  logic signed [63:0] add_res;
  logic signed [63:0] sum_abs;
  logic               ovf;

  logic [63:0]        ma;
  logic [23:0]        mb;
  logic               neg;
  logic               sat_neg;
  logic [31:0]        mul_a;
  logic [55:0]        mul_res;
  logic [55:0]        pph;
  logic [87:0]        prod;
  logic [87:0]        limit;
  logic               prod_ovf;
  logic               out_free;
  logic               out_load;

  assign uw         = UCODE[pc];
  assign item_stall = (pc != PC_WAIT);
  assign out_free   = !result_valid || !result_stall;
  assign out_load   = out_free && ((uw.op == OP_OUT_Q) || (uw.op == OP_OUT_BAD)
                                   || (uw.op == OP_OUT_SAT));

  assign bad_n = (count == '0) || count[0] || (int'(count) > MAX_PARTITIONS);
  assign diff     = 25'(upper) - 25'(lower);
  assign diff_abs = diff[24] ? -diff : diff;

  // restoring divide, one quotient bit per step
  assign div_r   = {rem, dq[63]};
  assign div_ge  = div_r >= {1'b0, dvs};
  assign div_sub = div_r - {1'b0, dvs};

  // divide by three, 16 quotient bits per step by reciprocal multiply
  assign d3_v    = {rem[1:0], dq[63:48]};
  assign d3_p    = 36'(d3_v) * 36'(D3_RECIP);
  assign d3_q    = d3_p[34:19];
  assign d3_back = 18'(d3_q) * 18'd3;
  assign d3_left = d3_v - d3_back;

  assign x_sum = 25'(x) + h;
  assign wsel  = ((idx == '0) || (idx == count)) ? 2'd0 : (idx[0] ? 2'd2 : 2'd1);

  // f(x) with 2*FRAC_BITS fraction bits, then weighted by 1, 2 or 4
  assign f_val = 52'(s1_sq) + (52'(s1_x) <<< (FRAC_BITS + 1)) - POLY_C;

  assign add_b   = 64'(s2_fw);
  assign add_t   = 65'(sum) + 65'(add_b);
  assign add_ovf = add_t[64] != add_t[63];
  assign add_res = add_ovf ? (add_b[63] ? INT_MIN : INT_MAX) : add_t[63:0];

  assign sum_abs = sum[63] ? -sum : sum;
  assign h_abs   = h[24] ? -h : h;

  assign mul_a    = (uw.op == OP_MULHI) ? ma[63:32] : ma[31:0];
  assign mul_res  = mul_a * mb;
  assign limit    = {24'b0, neg, {63{!neg}}};
  assign prod_ovf = prod > limit;

  always_comb begin
    unique case (uw.cond)
      CND_ITEM:     cond = item_valid;
      CND_BAD_N:    cond = bad_n;
      CND_DIV_MORE: cond = (cnt != '1);
      CND_PT_MORE:  cond = (idx != count);
      CND_OVF:      cond = ovf;
      CND_PROD_OVF: cond = prod_ovf;
      CND_OUT_FREE: cond = out_free;
      CND_D3_MORE:  cond = (cnt != 6'd3);
      default:      cond = 1'b0;
    endcase
    if (cond) begin
      pc_next = uw.target;
    end else if (uw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= PC_WAIT;
      cnt          <= '0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      pc   <= pc_next;
      s1_v <= (uw.op == OP_POINT);
      s2_v <= s1_v;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (s2_v) begin
        sum <= add_res;
        if (add_ovf) begin
          ovf <= 1'b1;
        end
      end
      unique case (uw.op)
        OP_WAIT: begin
          if (item_valid) begin
            lower <= lower_limit;
            upper <= upper_limit;
            count <= partitions;
          end
        end
        OP_CHECK: begin
          dq    <= 64'(diff_abs[23:0]);
          rem   <= '0;
          dvs   <= count;
          cnt   <= '0;
          h_neg <= diff[24];
        end
        OP_DIV: begin
          cnt <= cnt + 6'd1;
          if (div_ge) begin
            rem <= div_sub[12:0];
            dq  <= {dq[62:0], 1'b1};
          end else begin
            rem <= div_r[12:0];
            dq  <= {dq[62:0], 1'b0};
          end
        end
        OP_DIV3: begin
          cnt <= cnt + 6'd1;
          rem <= {11'b0, d3_left[1:0]};
          dq  <= {dq[47:0], d3_q};
        end
        OP_HSET: begin
          h   <= h_neg ? -25'(dq[23:0]) : 25'(dq[23:0]);
          x   <= lower;
          idx <= '0;
          sum <= '0;
          ovf <= 1'b0;
        end
        OP_POINT: begin
          s1_sq <= x * x;
          s1_x  <= x;
          s1_w  <= wsel;
          x     <= x_sum[23:0];
          idx   <= idx + 13'd1;
        end
        OP_MAGS: begin
          ma      <= sum_abs;
          mb      <= h_abs[23:0];
          neg     <= (sum[63] != h[24]) && (sum != '0) && (h != '0);
          sat_neg <= sum[63];
        end
        OP_MULLO: prod <= 88'(mul_res);
        OP_MULHI: pph  <= mul_res;
        OP_ACC:   prod <= prod + {pph, 32'b0};
        OP_OCHK: begin
          sat_neg <= neg;
          dq      <= prod[63:0] >> FRAC_BITS;
          rem     <= '0;
          cnt     <= '0;
        end
        OP_OUT_Q: begin
          if (out_free) begin
            integral <= neg ? -dq : dq;
            status   <= ST_OK;
          end
        end
        OP_OUT_BAD: begin
          if (out_free) begin
            integral <= '0;
            status   <= ST_BAD_COUNT;
          end
        end
        OP_OUT_SAT: begin
          if (out_free) begin
            integral <= sat_neg ? INT_MIN : INT_MAX;
            status   <= ST_SATURATED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_fw <= f_val <<< s1_w;
    end
  end

endmodule

// ----- sv/sifq_chk.sv -----
// port-level checker for the simpson integrator, with its bind
module sifq_chk (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [63:0] integral,
  input logic [1:0]  status
);
  import sifq_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("word accepted while previous one still in work");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_BAD_COUNT) |-> (integral == '0))
    else $error("bad count result is not zero");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_SATURATED) |-> (integral == INT_MIN || integral == INT_MAX))
    else $error("saturated result is not an extreme");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_OK || status == ST_BAD_COUNT || status == ST_SATURATED))
    else $error("unknown status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(integral) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind simpson_integral_fixed_quadratic sifq_chk u_sifq_chk (.*);
